[design/dii_pkg.sv]
// Shared types and constants for the download-info indication parser.
package dii_pkg;

	// Body layout
	localparam logic [15:0] HEAD_BYTES  = 16'd16;
	localparam logic [15:0] LEN_BYTES   = 16'd2;
	localparam logic [15:0] MOD_BYTES   = 16'd8;
	localparam logic [15:0] DLID_LAST   = 16'd3;
	localparam logic [15:0] BSIZE_LAST  = 16'd5;
	localparam logic [15:0] MODID_LAST  = 16'd1;
	localparam logic [15:0] MSIZE_LAST  = 16'd5;
	localparam logic [15:0] MVER_BYTE   = 16'd6;

	// Record kinds
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_MODULE  = 1'b1;

	// Output beat widths
	localparam int M_TDATA_W = 144;
	localparam int S_TDATA_W = 24;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_HEAD,
		PH_CDLEN,
		PH_CDSKIP,
		PH_NMOD,
		PH_MOD,
		PH_INFO,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic        record_kind;
		logic [31:0] download_id;
		logic [15:0] block_size;
		logic [15:0] module_count;
		logic [15:0] module_id;
		logic [31:0] module_size;
		logic [7:0]  module_version;
		logic [7:0]  info_length;
		logic [15:0] source_stream;
		logic        last_record;
	} record_t;

endpackage

[design/download_info_indication_parser_core.sv]
// Top level of the download-info indication parser.
//
//  port group | dir | tdata (low bit up)                          | tuser / tlast
//  s_*        | in  | data_byte[7:0], stream_id[23:8]             | tuser: start_of_body
//  m_*        | out | download_id, block_size, module_count,      | tuser: record_kind
//             |     | module_id, module_size, module_version,     | tlast: last_record
//             |     | info_length, source_stream                  |
//
// One input beat per cycle while s_tready is high; a record appears on m_* in the cycle
// after the beat that completes it. The byte field state machine updates once per beat and
// the result register holds one record. s_tready drops only while a record waits and m_tready
// is low. Reset clears the parser to idle and empties the result register.
module download_info_indication_parser_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dii_pkg::S_TDATA_W-1:0]   s_tdata,   // data_byte, stream_id
	input  logic                            s_tuser,   // start_of_body
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dii_pkg::M_TDATA_W-1:0]   m_tdata,   // download_id, block_size,
	                                                   // module_count, module_id,
	                                                   // module_size, module_version,
	                                                   // info_length, source_stream
	output logic                            m_tuser,   // record_kind
	output logic                            m_tlast    // last_record
);

	logic             beat;
	logic             emit;
	logic             load_ok;
	dii_pkg::record_t rec;
	dii_pkg::record_t rec_q;

	assign s_tready = load_ok;
	assign beat     = s_tvalid && load_ok;

	dii_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat          (beat),
		.data_byte     (s_tdata[7:0]),
		.start_of_body (s_tuser),
		.stream_id     (s_tdata[23:8]),
		.emit          (emit),
		.rec           (rec)
	);

	dii_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat    (beat),
		.emit    (emit),
		.rec     (rec),
		.take    (m_tready),
		.load_ok (load_ok),
		.valid   (m_tvalid),
		.rec_q   (rec_q)
	);

	// Pack the record onto the output beat
	assign m_tdata = {rec_q.source_stream, rec_q.info_length, rec_q.module_version,
		rec_q.module_size, rec_q.module_id, rec_q.module_count, rec_q.block_size,
		rec_q.download_id};
	assign m_tuser = rec_q.record_kind;
	assign m_tlast = rec_q.last_record;

endmodule

[design/dii_parser.sv]
// Byte-wise field state machine that tracks the message body and builds records.
module dii_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  beat,
	input  logic [7:0]            data_byte,
	input  logic                  start_of_body,
	input  logic [15:0]           stream_id,
	output logic                  emit,
	output dii_pkg::record_t      rec
);

	dii_pkg::phase_t phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] dlid_q, dlid_d;
	logic [15:0] bsize_q, bsize_d;
	logic [15:0] mleft_q, mleft_d;
	logic [15:0] mcount_q, mcount_d;
	logic [15:0] modid_q, modid_d;
	logic [31:0] msize_q, msize_d;
	logic [7:0]  mver_q, mver_d;
	logic [15:0] sid_q, sid_d;

	// Hold state between beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dii_pkg::PH_IDLE;
			count_q  <= '0;
			acc_q    <= '0;
			dlid_q   <= '0;
			bsize_q  <= '0;
			mleft_q  <= '0;
			mcount_q <= '0;
			modid_q  <= '0;
			msize_q  <= '0;
			mver_q   <= '0;
			sid_q    <= '0;
		end else if (beat) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			acc_q    <= acc_d;
			dlid_q   <= dlid_d;
			bsize_q  <= bsize_d;
			mleft_q  <= mleft_d;
			mcount_q <= mcount_d;
			modid_q  <= modid_d;
			msize_q  <= msize_d;
			mver_q   <= mver_d;
			sid_q    <= sid_d;
		end
	end

	// Restart on start flag, then advance one byte through the current field
	always_comb begin
		logic [15:0] cnt_inc;
		logic [15:0] cnt_dec;
		logic [15:0] left_dec;

		phase_d  = phase_q;
		count_d  = count_q;
		acc_d    = acc_q;
		dlid_d   = dlid_q;
		bsize_d  = bsize_q;
		mleft_d  = mleft_q;
		mcount_d = mcount_q;
		modid_d  = modid_q;
		msize_d  = msize_q;
		mver_d   = mver_q;
		sid_d    = sid_q;
		emit     = 1'b0;
		rec      = '0;

		if (start_of_body) begin
			phase_d  = dii_pkg::PH_HEAD;
			count_d  = '0;
			acc_d    = '0;
			dlid_d   = '0;
			bsize_d  = '0;
			mleft_d  = '0;
			mcount_d = '0;
			modid_d  = '0;
			msize_d  = '0;
			mver_d   = '0;
			sid_d    = stream_id;
		end

		cnt_inc  = count_d + 16'd1;
		cnt_dec  = count_d - 16'd1;
		left_dec = mleft_d - 16'd1;

		if (phase_d != dii_pkg::PH_IDLE && phase_d != dii_pkg::PH_DONE) begin
			acc_d = {acc_d[23:0], data_byte};
		end

		case (phase_d)
			dii_pkg::PH_IDLE, dii_pkg::PH_DONE: begin
				// drop the byte
			end
			dii_pkg::PH_HEAD: begin
				if (count_d == dii_pkg::DLID_LAST) begin
					dlid_d = acc_d;
				end else if (count_d == dii_pkg::BSIZE_LAST) begin
					bsize_d = acc_d[15:0];
				end
				if (cnt_inc >= dii_pkg::HEAD_BYTES) begin
					phase_d = dii_pkg::PH_CDLEN;
					count_d = '0;
				end else begin
					count_d = cnt_inc;
				end
			end
			dii_pkg::PH_CDLEN: begin
				if (cnt_inc >= dii_pkg::LEN_BYTES) begin
					count_d = acc_d[15:0];
					phase_d = (acc_d[15:0] == 16'd0) ? dii_pkg::PH_NMOD
						: dii_pkg::PH_CDSKIP;
				end else begin
					count_d = cnt_inc;
				end
			end
			dii_pkg::PH_CDSKIP: begin
				count_d = cnt_dec;
				if (cnt_dec == 16'd0) begin
					phase_d = dii_pkg::PH_NMOD;
				end
			end
			dii_pkg::PH_NMOD: begin
				if (cnt_inc < dii_pkg::LEN_BYTES) begin
					count_d = cnt_inc;
				end else begin
					mcount_d = acc_d[15:0];
					mleft_d  = acc_d[15:0];
					count_d  = '0;
					phase_d  = (acc_d[15:0] == 16'd0) ? dii_pkg::PH_DONE
						: dii_pkg::PH_MOD;
					emit = 1'b1;
					rec.record_kind   = dii_pkg::KIND_SUMMARY;
					rec.download_id   = dlid_d;
					rec.block_size    = bsize_d;
					rec.module_count  = acc_d[15:0];
					rec.source_stream = sid_d;
					rec.last_record   = (acc_d[15:0] == 16'd0);
				end
			end
			dii_pkg::PH_MOD: begin
				if (count_d == dii_pkg::MODID_LAST) begin
					modid_d = acc_d[15:0];
				end else if (count_d == dii_pkg::MSIZE_LAST) begin
					msize_d = acc_d;
				end else if (count_d == dii_pkg::MVER_BYTE) begin
					mver_d = data_byte;
				end
				if (cnt_inc < dii_pkg::MOD_BYTES) begin
					count_d = cnt_inc;
				end else begin
					mleft_d = left_dec;
					if (left_dec == 16'd0) begin
						phase_d = dii_pkg::PH_DONE;
						count_d = '0;
					end else if (data_byte == 8'd0) begin
						phase_d = dii_pkg::PH_MOD;
						count_d = '0;
					end else begin
						phase_d = dii_pkg::PH_INFO;
						count_d = {8'd0, data_byte};
					end
					emit = 1'b1;
					rec.record_kind    = dii_pkg::KIND_MODULE;
					rec.download_id    = dlid_d;
					rec.block_size     = bsize_d;
					rec.module_count   = mcount_d;
					rec.module_id      = modid_d;
					rec.module_size    = msize_d;
					rec.module_version = mver_d;
					rec.info_length    = data_byte;
					rec.source_stream  = sid_d;
					rec.last_record    = (left_dec == 16'd0);
				end
			end
			dii_pkg::PH_INFO: begin
				count_d = cnt_dec;
				if (cnt_dec == 16'd0) begin
					phase_d = dii_pkg::PH_MOD;
				end
			end
			default: begin
				phase_d = dii_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

[design/dii_out_reg.sv]
// Result register between the parser and the output stream.
module dii_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beat,
	input  logic             emit,
	input  dii_pkg::record_t rec,
	input  logic             take,
	output logic             load_ok,
	output logic             valid,
	output dii_pkg::record_t rec_q
);

	logic valid_q;

	// Register may load when empty or draining this cycle
	assign load_ok = !valid_q || take;
	assign valid   = valid_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= beat && emit;
		end
	end

	// Capture the record payload
	always_ff @(posedge clk) begin
		if (load_ok && beat && emit) begin
			rec_q <= rec;
		end
	end

endmodule

[tb/download_info_indication_parser_core_tb.sv]
// Self-checking testbench for the download-info indication parser core.
module download_info_indication_parser_core_tb;

	localparam int CYCLE_LIMIT = 400000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [dii_pkg::S_TDATA_W-1:0] s_tdata;   // data_byte, stream_id
	logic                          s_tuser;   // start_of_body
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [dii_pkg::M_TDATA_W-1:0] m_tdata;   // download_id, block_size, module_count,
	                                          // module_id, module_size, module_version,
	                                          // info_length, source_stream
	logic                          m_tuser;   // record_kind
	logic                          m_tlast;   // last_record

	int send_idle_pct;
	int recv_stall_pct;
	int cycles = 0;
	int n_messages;

	// Tracks the parse of the body stream and holds the records it must produce
	class dii_record_tracker;
		dii_pkg::phase_t  phase;
		logic [15:0]      fcount;
		logic [31:0]      acc;
		logic [31:0]      dl_id;
		logic [15:0]      blk;
		logic [15:0]      left;
		logic [15:0]      mod_id;
		logic [31:0]      mod_size;
		logic [7:0]       mod_ver;
		logic [15:0]      mod_cnt;
		logic [15:0]      src;
		dii_pkg::record_t pending_records[$];
		int               n_bytes;
		int               n_expected;
		int               n_checked;
		int               mismatches;

		function new();
			phase      = dii_pkg::PH_IDLE;
			fcount     = '0;
			acc        = '0;
			dl_id      = '0;
			blk        = '0;
			left       = '0;
			mod_id     = '0;
			mod_size   = '0;
			mod_ver    = '0;
			mod_cnt    = '0;
			src        = '0;
			n_bytes    = 0;
			n_expected = 0;
			n_checked  = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return pending_records.size();
		endfunction

		function void queue_record(logic kind, logic [7:0] info, logic last);
			dii_pkg::record_t r;
			r = '0;
			r.record_kind   = kind;
			r.download_id   = dl_id;
			r.block_size    = blk;
			r.module_count  = mod_cnt;
			r.source_stream = src;
			r.last_record   = last;
			if (kind == dii_pkg::KIND_MODULE) begin
				r.module_id      = mod_id;
				r.module_size    = mod_size;
				r.module_version = mod_ver;
				r.info_length    = info;
			end
			pending_records.insert(pending_records.size(), r);
			n_expected++;
		endfunction

		// Advance the field state machine by one accepted body byte
		function void take_byte(logic [7:0] b, logic sob, logic [15:0] sid);
			n_bytes++;
			if (sob) begin
				phase    = dii_pkg::PH_HEAD;
				fcount   = '0;
				acc      = '0;
				dl_id    = '0;
				blk      = '0;
				left     = '0;
				mod_id   = '0;
				mod_size = '0;
				mod_ver  = '0;
				mod_cnt  = '0;
				src      = sid;
			end
			if (phase == dii_pkg::PH_IDLE || phase == dii_pkg::PH_DONE)
				return;
			acc = {acc[23:0], b};
			case (phase)
				dii_pkg::PH_HEAD: begin
					if (fcount == dii_pkg::DLID_LAST)
						dl_id = acc;
					else if (fcount == dii_pkg::BSIZE_LAST)
						blk = acc[15:0];
					fcount++;
					if (fcount >= dii_pkg::HEAD_BYTES) begin
						phase  = dii_pkg::PH_CDLEN;
						fcount = '0;
					end
				end
				dii_pkg::PH_CDLEN: begin
					fcount++;
					if (fcount >= dii_pkg::LEN_BYTES) begin
						fcount = acc[15:0];
						phase  = (acc[15:0] == 16'd0) ? dii_pkg::PH_NMOD
							: dii_pkg::PH_CDSKIP;
					end
				end
				dii_pkg::PH_CDSKIP: begin
					fcount--;
					if (fcount == 16'd0)
						phase = dii_pkg::PH_NMOD;
				end
				dii_pkg::PH_NMOD: begin
					fcount++;
					if (fcount >= dii_pkg::LEN_BYTES) begin
						mod_cnt = acc[15:0];
						left    = mod_cnt;
						fcount  = '0;
						phase   = (left == 16'd0) ? dii_pkg::PH_DONE : dii_pkg::PH_MOD;
						queue_record(dii_pkg::KIND_SUMMARY, 8'h00, left == 16'd0);
					end
				end
				dii_pkg::PH_MOD: begin
					if (fcount == dii_pkg::MODID_LAST)
						mod_id = acc[15:0];
					else if (fcount == dii_pkg::MSIZE_LAST)
						mod_size = acc;
					else if (fcount == dii_pkg::MVER_BYTE)
						mod_ver = b;
					fcount++;
					if (fcount >= dii_pkg::MOD_BYTES) begin
						left--;
						if (left == 16'd0) begin
							phase  = dii_pkg::PH_DONE;
							fcount = '0;
						end else if (b == 8'h00) begin
							phase  = dii_pkg::PH_MOD;
							fcount = '0;
						end else begin
							phase  = dii_pkg::PH_INFO;
							fcount = {8'h00, b};
						end
						queue_record(dii_pkg::KIND_MODULE, b, left == 16'd0);
					end
				end
				dii_pkg::PH_INFO: begin
					fcount--;
					if (fcount == 16'd0)
						phase = dii_pkg::PH_MOD;
				end
				default: phase = dii_pkg::PH_IDLE;
			endcase
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				if (mismatches < 10)
					$display("record %0d: %s expected %h got %h", n_checked, name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one record from the bus with the oldest one owed
		function void match_record(dii_pkg::record_t got);
			dii_pkg::record_t want;
			if (pending_records.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected record: kind %0d id %h", got.record_kind,
						got.download_id);
				mismatches++;
				return;
			end
			want = pending_records.pop_front();
			check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
			check_field("download_id", want.download_id, got.download_id);
			check_field("block_size", 32'(want.block_size), 32'(got.block_size));
			check_field("module_count", 32'(want.module_count), 32'(got.module_count));
			check_field("module_id", 32'(want.module_id), 32'(got.module_id));
			check_field("module_size", want.module_size, got.module_size);
			check_field("module_version", 32'(want.module_version),
				32'(got.module_version));
			check_field("info_length", 32'(want.info_length), 32'(got.info_length));
			check_field("source_stream", 32'(want.source_stream), 32'(got.source_stream));
			check_field("last_record", 32'(want.last_record), 32'(got.last_record));
			n_checked++;
		endfunction
	endclass

	dii_record_tracker board;

	download_info_indication_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Unpack the record currently on the master side
	function dii_pkg::record_t on_bus();
		dii_pkg::record_t r;
		r.record_kind    = m_tuser;
		r.download_id    = m_tdata[31:0];
		r.block_size     = m_tdata[47:32];
		r.module_count   = m_tdata[63:48];
		r.module_id      = m_tdata[79:64];
		r.module_size    = m_tdata[111:80];
		r.module_version = m_tdata[119:112];
		r.info_length    = m_tdata[127:120];
		r.source_stream  = m_tdata[143:128];
		r.last_record    = m_tlast;
		return r;
	endfunction

	// Append one byte to the end of a body
	function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] b);
		q.insert(q.size(), b);
	endfunction

	// Check accepted records and stall the receiver at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.match_record(on_bus());
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("download_info_indication_parser_core test failed");
			$finish;
		end
	end

	// Offer one beat after a random gap and hold it until accepted
	task automatic send_beat(input logic [7:0] b, input logic sob, input logic [15:0] sid);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {sid, b};
		s_tuser  <= sob;
		do @(posedge clk); while (!s_tready);
		board.take_byte(b, sob, sid);
	endtask

	// Lay out a message body: header, descriptor, module count, modules with info
	task automatic build_body(ref logic [7:0] q[$], input logic [31:0] dlid,
		input logic [15:0] bsize, input logic [15:0] cdlen, input logic [15:0] nmod,
		input int mods, input int info_lo, input int info_hi);
		int cd_n;
		int info_n;
		logic [31:0] msize;
		q.delete();
		for (int i = 3; i >= 0; i--)
			add_byte(q, dlid[8*i +: 8]);
		add_byte(q, bsize[15:8]);
		add_byte(q, bsize[7:0]);
		repeat (10) add_byte(q, 8'($urandom));
		add_byte(q, cdlen[15:8]);
		add_byte(q, cdlen[7:0]);
		// long descriptors are only used where the message gets cut short
		cd_n = (cdlen > 16'd64) ? 4 : int'(cdlen);
		repeat (cd_n) add_byte(q, 8'($urandom));
		add_byte(q, nmod[15:8]);
		add_byte(q, nmod[7:0]);
		for (int m = 0; m < mods; m++) begin
			add_byte(q, 8'($urandom));
			add_byte(q, 8'($urandom));
			msize = $urandom;
			for (int i = 3; i >= 0; i--)
				add_byte(q, msize[8*i +: 8]);
			add_byte(q, 8'($urandom));
			info_n = $urandom_range(info_hi, info_lo);
			add_byte(q, 8'(info_n));
			repeat (info_n) add_byte(q, 8'($urandom));
		end
	endtask

	task automatic send_body(ref logic [7:0] q[$], input logic [15:0] sid);
		n_messages++;
		for (int i = 0; i < q.size(); i++)
			send_beat(q[i], i == 0, (i == 0) ? sid : 16'($urandom));
	endtask

	task automatic cut_body(ref logic [7:0] q[$], input int keep);
		while (q.size() > keep)
			void'(q.pop_back());
	endtask

	// Mostly well-formed messages, some cut short, some followed by stray bytes
	task automatic random_message();
		logic [7:0] body[$];
		logic [15:0] cdlen;
		int nmod;
		cdlen = ($urandom_range(7) == 0) ? 16'($urandom_range(40, 5)) : 16'($urandom_range(3));
		nmod  = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4);
		build_body(body, $urandom, 16'($urandom), cdlen, 16'(nmod), nmod, 0,
			($urandom_range(5) == 0) ? 20 : 4);
		if ($urandom_range(6) == 0)
			cut_body(body, $urandom_range(body.size(), 1));
		send_body(body, 16'($urandom));
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(4, 1)) send_beat(8'($urandom), 1'b0, 16'($urandom));
	endtask

	// Hold the sender off until every owed record has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	initial begin
		logic [7:0] body[$];
		int start_bytes;
		int start_recs;
		board          = new();
		n_messages     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes ahead of any start are dropped
		send_beat(8'h00, 1'b0, 16'h0000);
		send_beat(8'hFF, 1'b0, 16'hFFFF);
		// all-ones download id and block size, no descriptor, no modules: the summary is the last record
		build_body(body, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0, 0, 0, 0);
		send_body(body, 16'hFFFF);
		send_beat(8'hA5, 1'b0, 16'($urandom));
		// all-zero download id and block size, two modules without info
		build_body(body, 32'h0, 16'h0, 16'd1, 16'd2, 2, 0, 0);
		send_body(body, 16'h0000);
		// longest info run between modules; info of the final module is ignored
		build_body(body, $urandom, 16'($urandom), 16'd2, 16'd2, 2, 255, 255);
		cut_body(body, 300);
		send_body(body, 16'($urandom));
		// largest descriptor length, abandoned by the next start
		build_body(body, $urandom, 16'($urandom), 16'hFFFF, 16'd1, 1, 0, 0);
		cut_body(body, 24);
		send_body(body, 16'($urandom));
		// largest module count, abandoned after one module
		build_body(body, $urandom, 16'($urandom), 16'd0, 16'hFFFF, 1, 1, 1);
		send_body(body, 16'($urandom));
		// lone start byte, then restart
		send_beat(8'($urandom), 1'b1, 16'($urandom));
		n_messages++;
		drain();

		// random traffic under four idle mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			start_bytes = board.n_bytes;
			start_recs  = board.n_expected;
			while (board.n_bytes - start_bytes < 32 || board.n_expected - start_recs < 3)
				random_message();
			drain();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d messages, %0d body bytes, %0d records checked",
			n_messages, board.n_bytes, board.n_checked);
		$display("idle mixes: none, sender 83%%, receiver 83%%, both 23%%; %0d mismatches",
			board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("download_info_indication_parser_core test passed");
		end else begin
			$display("download_info_indication_parser_core test failed");
		end
		$finish;
	end

endmodule

[download_info_indication_parser_core.f]
design/dii_pkg.sv
design/dii_parser.sv
design/dii_out_reg.sv
design/download_info_indication_parser_core.sv
tb/download_info_indication_parser_core_tb.sv
